@@ rtl/core/mqsb_pkg.sv @@
`default_nettype none

package mqsb_pkg;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_LOOK   = 2'd1,
    S_UPDATE = 2'd2
  } mqsb_state_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } mqsb_status_e;

  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } mqsb_op_e;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mqsb_qt_ctl_t;

  typedef struct packed {
    logic rd_en;
    logic link_we;
    logic data_we;
  } mqsb_slot_ctl_t;

endpackage

`default_nettype wire

@@ rtl/core/mqsb_queue_table.sv @@
`default_nettype none

// Per-queue head/tail pointers. Read data is registered; a write to the
// entry being read at the same edge is forwarded.
module mqsb_queue_table #(
  parameter int NUM_QUEUES = 8,
  parameter int SLOTS      = 16,
  localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1,
  localparam int SW = $clog2(SLOTS + 1)
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire mqsb_pkg::mqsb_qt_ctl_t ctl_i,
  input  wire logic [QW-1:0]         rd_idx_i,
  input  wire logic [QW-1:0]         wr_idx_i,
  input  wire logic [SW-1:0]         wr_head_i,
  input  wire logic [SW-1:0]         wr_tail_i,
  output logic      [SW-1:0]         head_o,
  output logic      [SW-1:0]         tail_o
);

  localparam logic [SW-1:0] NullSlot = SW'(SLOTS);

  logic [2*SW-1:0]       mem [NUM_QUEUES];
  logic [NUM_QUEUES-1:0] vld_q;
  logic [2*SW-1:0]       ent_q;
  logic                  rd_vld_q;
  logic                  fwd;

  assign fwd = ctl_i.wr_en && (wr_idx_i == rd_idx_i);

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem[wr_idx_i] <= {wr_head_i, wr_tail_i};
    end
    if (ctl_i.rd_en) begin
      ent_q <= fwd ? {wr_head_i, wr_tail_i} : mem[rd_idx_i];
    end
  end

  // an entry never written reads as an empty queue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (ctl_i.wr_en) begin
        vld_q[wr_idx_i] <= 1'b1;
      end
      if (ctl_i.rd_en) begin
        rd_vld_q <= fwd || vld_q[rd_idx_i];
      end
    end
  end

  assign head_o = rd_vld_q ? ent_q[2*SW-1:SW] : NullSlot;
  assign tail_o = ent_q[SW-1:0];

endmodule

`default_nettype wire

@@ rtl/core/mqsb_slot_store.sv @@
`default_nettype none

// Link and data memories for all slots. Slots at or above the watermark
// have never been allocated and read their reset link (next slot).
module mqsb_slot_store #(
  parameter int SLOTS      = 16,
  parameter int DATA_WIDTH = 32,
  localparam int SW = $clog2(SLOTS + 1),
  localparam int LW = $clog2(SLOTS)
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire mqsb_pkg::mqsb_slot_ctl_t ctl_i,
  input  wire logic [SW-1:0]           rd_slot_i,
  input  wire logic [SW-1:0]           link_wr_slot_i,
  input  wire logic [SW-1:0]           link_wr_data_i,
  input  wire logic [SW-1:0]           data_wr_slot_i,
  input  wire logic [DATA_WIDTH-1:0]   data_wr_data_i,
  output logic      [SW-1:0]           link_rd_o,
  output logic      [DATA_WIDTH-1:0]   data_rd_o
);

  logic [SW-1:0]         link_mem [SLOTS];
  logic [DATA_WIDTH-1:0] data_mem [SLOTS];

  logic [SW-1:0]         link_rd_q;
  logic [DATA_WIDTH-1:0] data_rd_q;
  logic [SW-1:0]         rd_slot_q;
  logic [SW-1:0]         wm_q;
  logic                  fresh_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.link_we) begin
      link_mem[link_wr_slot_i[LW-1:0]] <= link_wr_data_i;
    end
    if (ctl_i.data_we) begin
      data_mem[data_wr_slot_i[LW-1:0]] <= data_wr_data_i;
    end
    if (ctl_i.rd_en) begin
      link_rd_q <= link_mem[rd_slot_i[LW-1:0]];
      data_rd_q <= data_mem[rd_slot_i[LW-1:0]];
      rd_slot_q <= rd_slot_i;
    end
  end

  // untouched slots are handed out in ascending order, so one count suffices
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wm_q    <= '0;
      fresh_q <= 1'b0;
    end else begin
      if (ctl_i.data_we && (data_wr_slot_i == wm_q)) begin
        wm_q <= wm_q + SW'(1);
      end
      if (ctl_i.rd_en) begin
        fresh_q <= (rd_slot_i >= wm_q);
      end
    end
  end

  assign link_rd_o = fresh_q ? (rd_slot_q + SW'(1)) : link_rd_q;
  assign data_rd_o = data_rd_q;

endmodule

`default_nettype wire

@@ rtl/core/multi_queue_shared_buffer.sv @@
// Several FIFO queues kept as linked lists in one shared slot buffer.
// Input channel: in_valid_i / in_stall_o with mode_i (0 enqueue, 1 dequeue),
// queue_id_i and value_i. Output channel: out_valid_o / out_stall_i with
// status_o (0 ok, 1 buffer full, 2 queue empty) and read_value_o, which is
// zero unless a dequeue succeeded. Every transaction yields one result.
// Sequence: after acceptance the queue table is read, then the slot
// memory, then the result is written back into the output register. A
// new transaction cannot start before the current one has read and written
// back the slot link memory and the free-list head; the next transaction
// is taken in the write-back cycle of the current one.
// Reset: all queues empty, every slot free in ascending order. No clearing
// pass is needed; a fill watermark supplies the reset links.
// Receiver stall: the result waits in the output register, a further
// transaction is still accepted and held in write-back until the output
// register frees.
`default_nettype none

module multi_queue_shared_buffer #(
  parameter int NUM_QUEUES = 8,
  parameter int SLOTS      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_stall_o,
  input  wire logic          mode_i,
  input  wire logic [2:0]    queue_id_i,
  input  wire logic signed [31:0] value_i,
  output logic               out_valid_o,
  input  wire                out_stall_i,
  output logic      [1:0]    status_o,
  output logic signed [31:0] read_value_o
);

  localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int SW = $clog2(SLOTS + 1);
  localparam logic [SW-1:0] NullSlot = SW'(SLOTS);

  mqsb_pkg::mqsb_state_e  state_q, state_d;
  mqsb_pkg::mqsb_status_e status_q, status_d;
  mqsb_pkg::mqsb_op_e     mode_q;

  logic            in_acc, done;
  logic [QW-1:0]   qidx_q;
  logic            q_ok_q;
  logic [31:0]     value_q;
  logic [SW-1:0]   free_head_q, free_head_d;
  logic            out_valid_q;
  logic [31:0]     read_value_q, read_value_d;

  mqsb_pkg::mqsb_qt_ctl_t   qt_ctl;
  mqsb_pkg::mqsb_slot_ctl_t slot_ctl;
  logic [SW-1:0] qt_head, qt_tail, qt_wr_head, qt_wr_tail;
  logic          qt_we, link_we, data_we;
  logic [SW-1:0] rd_slot, link_rd, link_wr_slot, link_wr_data;
  logic [DATA_WIDTH-1:0] data_rd;
  logic          head_ok, free_ok;

  assign done       = (state_q == mqsb_pkg::S_UPDATE) && (!out_valid_q || !out_stall_i);
  assign in_stall_o = !((state_q == mqsb_pkg::S_IDLE) || done);
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mqsb_pkg::S_IDLE;
      free_head_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      free_head_q <= free_head_d;
      out_valid_q <= done || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      mode_q  <= mqsb_pkg::mqsb_op_e'(mode_i);
      qidx_q  <= QW'(queue_id_i);
      q_ok_q  <= (32'(queue_id_i) < NUM_QUEUES);
      value_q <= value_i;
    end
    if (done) begin
      status_q     <= status_d;
      read_value_q <= read_value_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mqsb_pkg::S_IDLE: begin
        if (in_acc) state_d = mqsb_pkg::S_LOOK;
      end
      mqsb_pkg::S_LOOK: begin
        state_d = mqsb_pkg::S_UPDATE;
      end
      mqsb_pkg::S_UPDATE: begin
        if (done) state_d = in_acc ? mqsb_pkg::S_LOOK : mqsb_pkg::S_IDLE;
      end
      default: begin
        state_d = mqsb_pkg::S_IDLE;
      end
    endcase
  end

  // write-back: the tail slot's link is not cleared on enqueue, so a dequeue
  // of the tail slot takes null as the new head instead of reading it
  always_comb begin
    head_ok      = (qt_head < NullSlot);
    free_ok      = (free_head_q < NullSlot);
    status_d     = mqsb_pkg::ST_OK;
    read_value_d = '0;
    free_head_d  = free_head_q;
    qt_we        = 1'b0;
    qt_wr_head   = qt_head;
    qt_wr_tail   = qt_tail;
    link_we      = 1'b0;
    link_wr_slot = qt_head;
    link_wr_data = free_head_q;
    data_we      = 1'b0;
    if (mode_q == mqsb_pkg::OP_ENQ) begin
      if (!q_ok_q || !free_ok) begin
        status_d = mqsb_pkg::ST_FULL;
      end else begin
        free_head_d = link_rd;
        qt_we       = 1'b1;
        qt_wr_head  = head_ok ? qt_head : free_head_q;
        qt_wr_tail  = free_head_q;
        data_we     = 1'b1;
        if (head_ok && (qt_tail < NullSlot)) begin
          link_we      = 1'b1;
          link_wr_slot = qt_tail;
          link_wr_data = free_head_q;
        end
      end
    end else begin
      if (!q_ok_q || !head_ok) begin
        status_d = mqsb_pkg::ST_EMPTY;
      end else begin
        qt_we        = 1'b1;
        qt_wr_head   = (qt_head == qt_tail) ? NullSlot : link_rd;
        link_we      = 1'b1;
        free_head_d  = qt_head;
        read_value_d = 32'(data_rd);
      end
    end
    if (!done) begin
      free_head_d = free_head_q;
      qt_we       = 1'b0;
      link_we     = 1'b0;
      data_we     = 1'b0;
    end
  end

  assign qt_ctl.rd_en = in_acc;
  assign qt_ctl.wr_en = qt_we;

  assign rd_slot          = (mode_q == mqsb_pkg::OP_DEQ) ? qt_head : free_head_q;
  assign slot_ctl.rd_en   = (state_q == mqsb_pkg::S_LOOK);
  assign slot_ctl.link_we = link_we;
  assign slot_ctl.data_we = data_we;

  mqsb_queue_table #(
    .NUM_QUEUES (NUM_QUEUES),
    .SLOTS      (SLOTS)
  ) u_queue_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (qt_ctl),
    .rd_idx_i  (QW'(queue_id_i)),
    .wr_idx_i  (qidx_q),
    .wr_head_i (qt_wr_head),
    .wr_tail_i (qt_wr_tail),
    .head_o    (qt_head),
    .tail_o    (qt_tail)
  );

  mqsb_slot_store #(
    .SLOTS      (SLOTS),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_slot_store (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctl_i          (slot_ctl),
    .rd_slot_i      (rd_slot),
    .link_wr_slot_i (link_wr_slot),
    .link_wr_data_i (link_wr_data),
    .data_wr_slot_i (free_head_q),
    .data_wr_data_i (DATA_WIDTH'(value_q)),
    .link_rd_o      (link_rd),
    .data_rd_o      (data_rd)
  );

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign read_value_o = read_value_q;

  a_look_then_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == mqsb_pkg::S_LOOK |=> state_q == mqsb_pkg::S_UPDATE)
    else $error("slot read not followed by write-back");

  a_result_from_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == mqsb_pkg::S_UPDATE))
    else $error("result raised outside write-back");

  a_zero_on_failure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (status_q != mqsb_pkg::ST_OK)) |-> (read_value_q == '0))
    else $error("non-zero data with failing status");

  a_free_head_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_head_q <= NullSlot)
    else $error("free-list head out of range");

endmodule

`default_nettype wire
